// ===== rtl/srpa_pkg.sv =====
package srpa_pkg;

    // Fixed-point formats
    localparam int LOG_FRAC       = 24;   // fraction bits of a log2 value
    localparam int RATE_W         = 32;   // spread rate, unsigned
    localparam int RATE_FRAC_BITS = 16;   // fraction bits of the spread rate
    localparam int D_W            = 51;   // rate^0.6 in Q26, up to and with 2^50
    localparam int NUM_FUELS      = 12;

    // Unit latencies in clock cycles
    localparam int LOG_LAT = 2 + LOG_FRAC;  // find msb, normalize, one bit per squaring
    localparam int POW_LAT = LOG_FRAC + 4;  // load, one factor per bit, product, shift, clamp

    localparam logic [63:0] RATE_CAP = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] D_CAP    = 64'h0004_0000_0000_0000;

    // Integer square root, used only at elaboration to build the 2^(2^-k) factors
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != '0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(2^-k) in Q31, truncated chain of square roots
    function automatic logic [31:0] pow_const(input int k);
        logic [63:0] c;
        c = isqrt64(64'h8000_0000_0000_0000);
        for (int j = 2; j <= LOG_FRAC; j++) begin
            if (j <= k) c = isqrt64({c[32:0], 31'd0});
        end
        return c[31:0];
    endfunction

endpackage

// ===== rtl/srpa_log2.sv =====
// Pipelined log2 of a positive integer, Q24 result, truncated.
// One squaring of the normalized mantissa per stage gives one fraction bit.
module srpa_log2 #(
    parameter int X_W = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic [X_W-1:0]                             i_x,
    output logic [$clog2(X_W)+srpa_pkg::LOG_FRAC-1:0]  o_log
);

    localparam int P_W = $clog2(X_W);
    localparam int NST = srpa_pkg::LOG_FRAC;

    logic [X_W-1:0] r_xa;
    logic [P_W-1:0] r_pa;
    logic [P_W-1:0] msb;
    logic [X_W-1:0] xs;

    logic [31:0]    r_m  [0:NST];
    logic [NST-1:0] r_fr [0:NST];
    logic [P_W-1:0] r_pb [0:NST];

    // Leading one position
    always_comb begin
        msb = '0;
        for (int i = 0; i < X_W; i++) begin
            if (i_x[i]) msb = P_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xa <= i_x;
            r_pa <= msb;
        end
    end

    // Normalize to a Q31 mantissa in [1,2), bits below dropped
    assign xs = r_xa << (P_W'(X_W - 1) - r_pa);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= xs[X_W-1 -: 32];
            r_fr[0] <= '0;
            r_pb[0] <= r_pa;
        end
    end

    // Square, and halve when the square reaches 2.0
    for (genvar k = 1; k <= NST; k++) begin : g_sq
        logic [63:0] sq;
        assign sq = 64'(r_m[k-1]) * 64'(r_m[k-1]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k]  <= sq[63] ? sq[63:32] : sq[62:31];
                r_fr[k] <= {r_fr[k-1][NST-2:0], sq[63]};
                r_pb[k] <= r_pb[k-1];
            end
        end
    end

    assign o_log = {r_pb[NST], r_fr[NST]};

endmodule

// ===== rtl/srpa_pow2.sv =====
// Pipelined m * 2^y with y in signed Q24, rounded half up and clamped at CAP.
// One conditional Q31 factor per fraction bit, then product, shift and clamp.
module srpa_pow2 #(
    parameter int          M_W   = 32,
    parameter int          OUT_W = 32,
    parameter logic [63:0] CAP   = 64'h0000_0000_FFFF_FFFF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [M_W-1:0]     i_m,
    input  logic signed [31:0] i_y,
    output logic [OUT_W-1:0]   o_r
);

    localparam int NST = srpa_pkg::LOG_FRAC;

    logic [M_W-1:0]    r_m   [0:NST];
    logic [31:0]       r_acc [0:NST];
    logic [NST-1:0]    r_fr  [0:NST];
    logic signed [7:0] r_n   [0:NST];

    // Split the exponent into integer and fraction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]   <= i_m;
            r_acc[0] <= 32'h8000_0000;
            r_fr[0]  <= i_y[NST-1:0];
            r_n[0]   <= i_y[31:24];
        end
    end

    // Multiply in 2^(2^-k) for each set fraction bit
    for (genvar k = 1; k <= NST; k++) begin : g_fac
        localparam logic [31:0] C_K = srpa_pkg::pow_const(k);
        logic [63:0] prod;
        assign prod = 64'(r_acc[k-1]) * 64'(C_K) + 64'h0000_0000_4000_0000;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= r_fr[k-1][NST-k] ? prod[62:31] : r_acc[k-1];
                r_m[k]   <= r_m[k-1];
                r_fr[k]  <= r_fr[k-1];
                r_n[k]   <= r_n[k-1];
            end
        end
    end

    // Mantissa times fraction factor
    logic [63:0]       r_p;
    logic signed [7:0] r_pn;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= 64'(r_m[NST]) * 64'(r_acc[NST]);
            r_pn <= r_n[NST];
        end
    end

    // Shift by the integer part: right with rounding, or left with overflow check
    logic signed [9:0] sh_s;
    logic signed [9:0] sh_l;
    logic [5:0]        amt_r;
    logic [63:0]       r_t;
    logic [63:0]       r_lsh;
    logic [63:0]       r_capsh;
    logic [63:0]       r_p2;
    logic              r_right;
    logic              r_big;
    logic              r_lbig;
    logic              r_zero;

    assign sh_s  = 10'sd31 - 10'(r_pn);
    assign sh_l  = -sh_s;
    assign amt_r = 6'(sh_s - 10'sd1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= r_p >> amt_r;
            r_lsh   <= r_p << sh_l[5:0];
            r_capsh <= CAP >> sh_l[5:0];
            r_p2    <= r_p;
            r_right <= sh_s > 10'sd0;
            r_big   <= sh_s > 10'sd64;
            r_lbig  <= sh_l >= 10'sd64;
            r_zero  <= r_p == '0;
        end
    end

    // Round, clamp
    logic [63:0] rr_right;
    logic [63:0] rr;
    logic [63:0] res;
    logic        ovf;
    logic [OUT_W-1:0] r_res;

    always_comb begin
        rr_right = r_big ? '0 : (r_t >> 1) + 64'(r_t[0]);
        ovf      = r_lbig || (r_p2 > r_capsh);
        rr       = r_right ? rr_right : (ovf ? CAP : r_lsh);
        res      = r_zero ? '0 : ((rr > CAP) ? CAP : rr);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_res <= res[OUT_W-1:0];
    end

    assign o_r = r_res;

endmodule

// ===== rtl/spread_rate_percentile_adjust.sv =====
// Percentile spread-rate adjustment. Takes one item per clock while the output
// is not stalled and returns one result per item, in order. The depth is set by
// the crown path, which runs two 26-stage log2 units (one squaring per fraction
// bit) and two 28-stage pow2 units (one 32x32 factor multiply per exponent
// fraction bit) in series; the exp-scaled and pass-through results are aligned
// to it. A stall on the output freezes the whole pipeline, so nothing is lost or
// repeated. Configuration must be written through i_cfg_we/i_cfg_idx/i_cfg_data
// while no items are in flight (unenforced); reset clears config and valid bits.
module spread_rate_percentile_adjust (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_fuel_index,
    input  logic [31:0] i_rate_in,
    input  logic [15:0] i_crown_fraction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_rate_out,
    output logic [1:0]  o_path_code
);

    // Register indexes
    localparam logic [2:0] CFG_TINV    = 3'd0;
    localparam logic [2:0] CFG_SURF    = 3'd1;
    localparam logic [2:0] CFG_CROWN   = 3'd2;
    localparam logic [2:0] CFG_SLOPE_A = 3'd3;
    localparam logic [2:0] CFG_SLOPE_B = 3'd4;
    localparam logic [2:0] CFG_SLOPE_C = 3'd5;

    typedef enum logic [1:0] {
        PATH_PASS     = 2'd0,
        PATH_EXP      = 2'd1,
        PATH_CROWN    = 2'd2,
        PATH_FALLBACK = 2'd3
    } t_path;

    typedef struct packed {
        logic [31:0]        rate;
        logic signed [32:0] e;
        logic               is_exp;
        logic               is_crown;
        logic               fall;
        logic               zsum;
    } t_side;

    // Pipeline stage positions
    localparam int ST_DEC    = 1;
    localparam int ST_L1     = ST_DEC + srpa_pkg::LOG_LAT;
    localparam int ST_D1     = ST_L1 + 3;
    localparam int ST_P1     = ST_D1 + srpa_pkg::POW_LAT;
    localparam int ST_SUM    = ST_P1 + 1;
    localparam int ST_L2     = ST_SUM + srpa_pkg::LOG_LAT;
    localparam int ST_D2     = ST_L2 + 3;
    localparam int ST_LAST   = ST_D2 + srpa_pkg::POW_LAT;
    localparam int ST_EXP_IN = ST_LAST - srpa_pkg::POW_LAT;

    localparam int LR_W = $clog2(srpa_pkg::RATE_W) + srpa_pkg::LOG_FRAC;
    localparam int LS_W = $clog2(srpa_pkg::D_W) + srpa_pkg::LOG_FRAC;

    // Divide-by-constant helpers (offsets keep the dividend positive)
    localparam logic [31:0] M5      = 32'd3435973837;
    localparam logic [31:0] M3      = 32'd2863311531;
    localparam int          U1_BASE = (75 + 2 * srpa_pkg::RATE_FRAC_BITS) * (2 ** 24);
    localparam int          Y1_OFS  = (11 - srpa_pkg::RATE_FRAC_BITS) * (2 ** 24);
    localparam int          U2_BASE = 20 * (2 ** 24);
    localparam int          Y2_OFS  = (srpa_pkg::RATE_FRAC_BITS - 50) * (2 ** 24);

    localparam logic signed [47:0] LOG2E_Q30 = 48'sd1549082005;
    localparam logic [15:0]        CF_TENTH  = 16'd3277;

    // Configuration registers
    logic signed [15:0] r_tinv;
    logic [11:0]        r_surf_mask;
    logic [11:0]        r_crown_mask;
    logic [63:0]        r_slopes_a;
    logic [63:0]        r_slopes_b;
    logic [63:0]        r_slopes_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tinv       <= '0;
            r_surf_mask  <= '0;
            r_crown_mask <= '0;
            r_slopes_a   <= '0;
            r_slopes_b   <= '0;
            r_slopes_c   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TINV:    r_tinv       <= i_cfg_data[15:0];
                CFG_SURF:    r_surf_mask  <= i_cfg_data[11:0];
                CFG_CROWN:   r_crown_mask <= i_cfg_data[11:0];
                CFG_SLOPE_A: r_slopes_a   <= i_cfg_data;
                CFG_SLOPE_B: r_slopes_b   <= i_cfg_data;
                CFG_SLOPE_C: r_slopes_c   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Exp scaling exponent, follows tinv
    logic signed [47:0] r_exp_prod;
    logic signed [31:0] r_exp_y;
    logic signed [47:0] exp_rnd;

    assign exp_rnd = (r_exp_prod + 48'sd131072) >>> 18;

    always_ff @(posedge i_clk) begin
        r_exp_prod <= 48'(r_tinv) * LOG2E_Q30;
        r_exp_y    <= exp_rnd[31:0];
    end

    // Handshake: the pipeline moves whenever the output register is empty or being taken
    logic         adv;
    logic         r_out_vld;
    logic [ST_LAST:0] r_vld;

    assign adv        = !r_out_vld || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[ST_LAST-1:0], i_in_valid};
            r_out_vld <= r_vld[ST_LAST];
        end
    end

    // Input stage
    logic [3:0]  r_in_fuel;
    logic [31:0] r_in_rate;
    logic [15:0] r_in_cf;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_fuel <= i_fuel_index;
            r_in_rate <= i_rate_in;
            r_in_cf   <= i_crown_fraction;
        end
    end

    // Decode: path selection and e = tinv * slope
    logic        in_tab;
    logic        low_cf;
    logic [63:0] slope_word;
    logic [15:0] slope;
    t_side       side_dec;

    always_comb begin
        in_tab = r_in_fuel < 4'(srpa_pkg::NUM_FUELS);
        low_cf = r_in_cf < CF_TENTH;
        unique case (r_in_fuel[3:2])
            2'd0:    slope_word = r_slopes_a;
            2'd1:    slope_word = r_slopes_b;
            default: slope_word = r_slopes_c;
        endcase
        slope = slope_word[{r_in_fuel[1:0], 4'd0} +: 16];

        side_dec.rate     = r_in_rate;
        side_dec.e        = 33'(r_tinv) * $signed({17'd0, slope});
        side_dec.is_exp   = in_tab && low_cf && r_surf_mask[r_in_fuel];
        side_dec.is_crown = in_tab && !low_cf && r_crown_mask[r_in_fuel];
        side_dec.fall     = 1'b0;
        side_dec.zsum     = 1'b0;
    end

    // Side data travels with each item
    t_side r_side [ST_DEC:ST_LAST];

    logic [srpa_pkg::D_W-1:0] d_val;
    logic [srpa_pkg::D_W-1:0] d_use;
    logic signed [52:0]       sum_s;
    t_side                    side_sum;

    // The sum stage picks up the sign and zero flags of d + e
    always_comb begin
        side_sum      = r_side[ST_P1];
        side_sum.fall = sum_s[52];
        side_sum.zsum = sum_s == '0;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[ST_DEC] <= side_dec;
            for (int k = ST_DEC + 1; k <= ST_LAST; k++) begin
                r_side[k] <= (k == ST_SUM) ? side_sum : r_side[k-1];
            end
        end
    end

    // log2 of the rate
    logic [LR_W-1:0] log_rate;

    srpa_log2 #(
        .X_W (srpa_pkg::RATE_W)
    ) u_log_rate (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_side[ST_DEC].rate),
        .o_log (log_rate)
    );

    // y1 = floor(3*(log - F)/5) + 26, as log + floor(u/5) + offset
    logic [31:0]     u1;
    logic [63:0]     q1_prod;
    logic [30:0]     r_d1_u;
    logic [LR_W-1:0] r_d1_log;
    logic [29:0]     r_d1_q;
    logic [LR_W-1:0] r_d1_log2;
    logic signed [31:0] r_y1;

    assign u1      = 32'(U1_BASE) - 32'({log_rate, 1'b0});
    assign q1_prod = 64'(r_d1_u) * 64'(M5);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1_u    <= u1[30:0];
            r_d1_log  <= log_rate;
            r_d1_q    <= q1_prod[63:34];
            r_d1_log2 <= r_d1_log;
            r_y1      <= 32'(r_d1_log2) + 32'(r_d1_q) + 32'(Y1_OFS);
        end
    end

    // d = rate^0.6 in Q26
    srpa_pow2 #(
        .M_W   (1),
        .OUT_W (srpa_pkg::D_W),
        .CAP   (srpa_pkg::D_CAP)
    ) u_pow_d (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_m   (1'b1),
        .i_y   (r_y1),
        .o_r   (d_val)
    );

    // s = d + e; negative s means fall back to exp scaling
    logic [srpa_pkg::D_W-1:0] r_s;

    assign d_use = (r_side[ST_P1].rate == '0) ? '0 : d_val;
    assign sum_s = $signed({2'b00, d_use}) + 53'(r_side[ST_P1].e);

    always_ff @(posedge i_clk) begin
        if (adv) r_s <= sum_s[srpa_pkg::D_W-1:0];
    end

    // log2 of the sum
    logic [LS_W-1:0] log_sum;

    srpa_log2 #(
        .X_W (srpa_pkg::D_W)
    ) u_log_sum (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_s),
        .o_log (log_sum)
    );

    // y2 = floor(5*(log - 26)/3) + F, as log + floor(u/3) + offset
    logic [31:0]     u2;
    logic [63:0]     q2_prod;
    logic [30:0]     r_d2_u;
    logic [LS_W-1:0] r_d2_log;
    logic [29:0]     r_d2_q;
    logic [LS_W-1:0] r_d2_log2;
    logic signed [31:0] r_y2;

    assign u2      = 32'({log_sum, 1'b0}) + 32'(U2_BASE);
    assign q2_prod = 64'(r_d2_u) * 64'(M3);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d2_u    <= u2[30:0];
            r_d2_log  <= log_sum;
            r_d2_q    <= q2_prod[62:33];
            r_d2_log2 <= r_d2_log;
            r_y2      <= 32'(r_d2_log2) + 32'(r_d2_q) + 32'(Y2_OFS);
        end
    end

    // Crown power-law result
    logic [31:0] fin_val;

    srpa_pow2 #(
        .M_W   (1),
        .OUT_W (srpa_pkg::RATE_W),
        .CAP   (srpa_pkg::RATE_CAP)
    ) u_pow_fin (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_m   (1'b1),
        .i_y   (r_y2),
        .o_r   (fin_val)
    );

    // Exp-scaled rate, started late so it lands with the crown result
    logic [31:0] exp_val;

    srpa_pow2 #(
        .M_W   (srpa_pkg::RATE_W),
        .OUT_W (srpa_pkg::RATE_W),
        .CAP   (srpa_pkg::RATE_CAP)
    ) u_pow_exp (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_m   (r_side[ST_EXP_IN].rate),
        .i_y   (r_exp_y),
        .o_r   (exp_val)
    );

    // Result select and output register
    t_side       sd;
    logic [31:0] res;
    t_path       code;
    logic [31:0] r_out_rate;
    t_path       r_out_path;

    always_comb begin
        sd = r_side[ST_LAST];
        priority if (sd.is_exp) begin
            res  = exp_val;
            code = PATH_EXP;
        end else if (sd.is_crown && sd.fall) begin
            res  = exp_val;
            code = PATH_FALLBACK;
        end else if (sd.is_crown) begin
            res  = sd.zsum ? '0 : fin_val;
            code = PATH_CROWN;
        end else begin
            res  = sd.rate;
            code = PATH_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_rate <= res;
            r_out_path <= code;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_rate_out  = r_out_rate;
    assign o_path_code = r_out_path;

    // Checks
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_fall_not_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_SUM] && r_side[ST_SUM].fall) |-> !r_side[ST_SUM].zsum)
        else $error("fallback flagged on a zero sum");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_vld[ST_LAST]))
        else $error("output valid without an item in the last stage");

endmodule
